[src/tilt_and_heading_angles_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tilt and heading block
// Assertion forms used by the back part RTL file of this block.
// ---------------------------------------------------------------------------
`ifndef TILT_AND_HEADING_ANGLES_MACROS_SVH
`define TILT_AND_HEADING_ANGLES_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define TH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/tha_pkg.sv]
// ---------------------------------------------------------------------------
// Tilt and heading package
// Shared constants, widths and the arctangent table of the CORDIC.
// ---------------------------------------------------------------------------
package tha_pkg;

  localparam int CordicStepsDef  = 16;
  localparam int AngleFracDef    = 7;
  localparam int TableLen        = 24;
  localparam int ZBits           = 20;
  localparam int ZW              = 32;  // angle accumulator, 2^-20 degree
  localparam int XW              = 52;  // CORDIC datapath; heading vectors grow to 2^48.3
  localparam int SqW             = 33;  // sum of two squares
  localparam int RootW           = 25;  // sqrt(sum * 2^16)
  localparam int DepthQ          = 4;

  // Item classification done by the front part.
  typedef enum logic [1:0] {
    SPEC_NONE = 2'd0,
    SPEC_POS  = 2'd1,
    SPEC_NEG  = 2'd2,
    SPEC_ZERO = 2'd3
  } spec_t;

  typedef enum logic [1:0] {
    HOFS_NONE = 2'd0,
    HOFS_ADD  = 2'd1,
    HOFS_SUB  = 2'd2
  } hofs_t;

  // One classified item as queued between front and back.
  typedef struct packed {
    logic [SqW-1:0]   pden2;
    logic [SqW-1:0]   rden2;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [16:0] hx;
    logic signed [16:0] hy;
    spec_t            pspec;
    spec_t            rspec;
    spec_t            hspec;
    hofs_t            hofs;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 32'sd47185920;  1: v = 32'sd27855475;  2: v = 32'sd14718068;
      3: v = 32'sd7471121;   4: v = 32'sd3750058;   5: v = 32'sd1876857;
      6: v = 32'sd938658;    7: v = 32'sd469357;    8: v = 32'sd234682;
      9: v = 32'sd117342;    10: v = 32'sd58671;    11: v = 32'sd29335;
      12: v = 32'sd14668;    13: v = 32'sd7334;     14: v = 32'sd3667;
      15: v = 32'sd1833;     16: v = 32'sd917;      17: v = 32'sd458;
      18: v = 32'sd229;      19: v = 32'sd115;      20: v = 32'sd57;
      21: v = 32'sd29;       22: v = 32'sd14;       23: v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/tha_front.sv]
// ---------------------------------------------------------------------------
// Tilt and heading front part
// Accepts sample sets, squares the tilt denominators and classifies the
// special cases, then pushes one item into the queue.
// ---------------------------------------------------------------------------
module tha_front
  import tha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic signed [15:0] mx,
  input  logic signed [15:0] my,
  output logic        push,
  output item_t       item,
  input  logic        q_ready
);

  logic        s1_v_r, s1_v_nxt;
  logic signed [15:0] ax_r, ay_r, az_r, mx_r, my_r;
  logic [31:0] sx_r, sy_r, sz_r;
  logic        s1_go;

  // A stage moves when its slot is empty or the queue takes it.
  assign s1_go    = !s1_v_r || q_ready;
  assign in_ready = s1_go;
  assign s1_v_nxt = s1_go ? in_valid : s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_valid) begin
      ax_r <= ax; ay_r <= ay; az_r <= az; mx_r <= mx; my_r <= my;
      sx_r <= 32'(ax * ax);
      sy_r <= 32'(ay * ay);
      sz_r <= 32'(az * az);
    end
  end

  function automatic spec_t tilt_spec(logic [SqW-1:0] d, logic signed [15:0] n);
    spec_t s;
    if (d != '0)     s = SPEC_NONE;
    else if (n > 0)  s = SPEC_POS;
    else if (n < 0)  s = SPEC_NEG;
    else             s = SPEC_ZERO;
    return s;
  endfunction

  always_comb begin
    item.pden2 = {1'b0, sy_r} + {1'b0, sz_r};
    item.rden2 = {1'b0, sx_r} + {1'b0, sz_r};
    item.ax    = ax_r;
    item.ay    = ay_r;
    item.pspec = tilt_spec(item.pden2, ax_r);
    item.rspec = tilt_spec(item.rden2, ay_r);
    item.hspec = (mx_r == '0 && my_r == '0) ? SPEC_ZERO : SPEC_NONE;
    if (mx_r < 0) begin
      item.hx   = -17'(mx_r);
      item.hy   = -17'(my_r);
      item.hofs = (my_r >= 0) ? HOFS_ADD : HOFS_SUB;
    end else begin
      item.hx   = 17'(mx_r);
      item.hy   = 17'(my_r);
      item.hofs = HOFS_NONE;
    end
  end

  assign push = s1_v_r && q_ready;

endmodule

[src/tha_queue.sv]
// ---------------------------------------------------------------------------
// Tilt and heading item queue
// Short first-in first-out queue between the front and back parts.
// ---------------------------------------------------------------------------
module tha_queue
  import tha_pkg::*;
#(
  parameter int Depth = DepthQ
)(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output item_t head,
  output logic  not_empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t            mem_r [Depth];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  assign not_full  = cnt_r != (AW+1)'(Depth);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp_nxt  = push ? inc(wp_r) : wp_r;
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

[src/tha_back.sv]
// ---------------------------------------------------------------------------
// Tilt and heading back part
// Square roots for the tilt denominators, three pipelined vectoring CORDICs
// and the final rounding, clamping and output register.
// ---------------------------------------------------------------------------
`include "tilt_and_heading_angles_macros.svh"

module tha_back
  import tha_pkg::*;
#(
  parameter int CordicSteps = CordicStepsDef,
  parameter int AngleFrac   = AngleFracDef
)(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output logic signed [14:0] pitch,
  output logic signed [14:0] roll,
  output logic signed [15:0] heading
);

  localparam int NIt  = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int RSt  = RootW;            // one result bit per root stage
  localparam int NSt  = RSt + NIt + 1;    // + final stage
  localparam int RadW = 2 * RootW;        // radicand den2 << 16
  localparam int Shf  = ZBits - AngleFrac;

  typedef struct packed {
    logic [RadW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cv_t;

  typedef struct packed {
    spec_t pspec;
    spec_t rspec;
    spec_t hspec;
    hofs_t hofs;
  } side_t;

  // Stage registers; index k holds the state after stage k.
  logic         v_r    [NSt+1];
  logic         adv;
  side_t        sd_r   [NSt+1];
  sq_t          psq_r  [RSt+1];
  sq_t          rsq_r  [RSt+1];
  logic signed [15:0] pn_r [RSt+1];
  logic signed [15:0] rn_r [RSt+1];
  logic signed [16:0] hx_r [RSt+1];
  logic signed [16:0] hy_r [RSt+1];
  cv_t          pc_r   [NIt+1];
  cv_t          rc_r   [NIt+1];
  cv_t          hc_r   [NIt+1];

  logic signed [14:0] pitch_r, roll_r;
  logic signed [15:0] head_r;

  // Whole pipeline moves together; the output register frees it.
  assign adv       = !v_r[NSt] || out_ready;
  assign pop       = adv && q_valid;
  assign out_valid = v_r[NSt];
  assign pitch     = pitch_r;
  assign roll      = roll_r;
  assign heading   = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSt; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int k = 1; k <= NSt; k++) v_r[k] <= v_r[k-1];
    end
  end

  function automatic sq_t root_step(sq_t s, int k);
    sq_t o;
    logic [RadW-1:0]  r2;
    logic [RootW+1:0] trial;
    logic [RootW+1:0] top;
    int sh;
    sh    = 2 * (RootW - 1 - k);
    r2    = s.rem;
    top   = (RootW+2)'(r2 >> sh);
    trial = {s.root, 2'b01};
    o.root = s.root << 1;
    o.rem  = r2;
    if (top >= trial) begin
      o.rem  = r2 - (RadW'(trial) << sh);
      o.root = (s.root << 1) | RootW'(1);
    end
    return o;
  endfunction

  function automatic cv_t cordic_step(cv_t c, int i);
    cv_t o;
    logic signed [XW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.y < 0) begin
      o.x = c.x - ys; o.y = c.y + xs; o.z = c.z - atan_tab(i);
    end else begin
      o.x = c.x + ys; o.y = c.y - xs; o.z = c.z + atan_tab(i);
    end
    return o;
  endfunction

  // Stage 0: load radicands; root stages hold remainder and partial root.
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0]  <= '{q_item.pspec, q_item.rspec, q_item.hspec, q_item.hofs};
      psq_r[0] <= '{RadW'(q_item.pden2) << 16, '0};
      rsq_r[0] <= '{RadW'(q_item.rden2) << 16, '0};
      pn_r[0]  <= q_item.ax;
      rn_r[0]  <= q_item.ay;
      hx_r[0]  <= q_item.hx;
      hy_r[0]  <= q_item.hy;
      for (int k = 1; k <= NSt; k++) sd_r[k] <= sd_r[k-1];
      for (int k = 1; k <= RSt; k++) begin
        psq_r[k] <= root_step(psq_r[k-1], k - 1);
        rsq_r[k] <= root_step(rsq_r[k-1], k - 1);
        pn_r[k]  <= pn_r[k-1];
        rn_r[k]  <= rn_r[k-1];
        hx_r[k]  <= hx_r[k-1];
        hy_r[k]  <= hy_r[k-1];
      end
    end
  end

  // CORDIC operands: tilt y is num*2^8 and heading operands x*2^16, all
  // times a further 2^16.
  always_comb begin
    pc_r[0].x = XW'(psq_r[RSt].root) <<< 16;
    pc_r[0].y = XW'(pn_r[RSt]) <<< 24;
    pc_r[0].z = '0;
    rc_r[0].x = XW'(rsq_r[RSt].root) <<< 16;
    rc_r[0].y = XW'(rn_r[RSt]) <<< 24;
    rc_r[0].z = '0;
    hc_r[0].x = XW'(hx_r[RSt]) <<< 32;
    hc_r[0].y = XW'(hy_r[RSt]) <<< 32;
    hc_r[0].z = '0;
  end

  for (genvar i = 1; i <= NIt; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        pc_r[i] <= cordic_step(pc_r[i-1], i - 1);
        rc_r[i] <= cordic_step(rc_r[i-1], i - 1);
        hc_r[i] <= cordic_step(hc_r[i-1], i - 1);
      end
    end
  end

  function automatic logic signed [ZW:0] to_units(logic signed [ZW:0] z, int lim_deg);
    logic signed [ZW:0] r, lim;
    lim = (ZW+1)'(lim_deg) <<< AngleFrac;
    r   = (z + ((ZW+1)'(1) <<< (Shf - 1))) >>> Shf;
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [14:0] tilt_out(spec_t s, logic signed [ZW-1:0] z);
    logic signed [ZW:0] full;
    logic signed [ZW:0] r;
    full = (ZW+1)'(90) <<< AngleFrac;
    case (s)
      SPEC_POS:  r = full;
      SPEC_NEG:  r = -full;
      SPEC_ZERO: r = '0;
      default:   r = to_units((ZW+1)'(z), 90);
    endcase
    return r[14:0];
  endfunction

  function automatic logic signed [15:0] head_out(side_t s, logic signed [ZW-1:0] z);
    logic signed [ZW:0] zz, half, r;
    half = (ZW+1)'(180) <<< ZBits;
    zz   = (ZW+1)'(z);
    case (s.hofs)
      HOFS_ADD: zz = zz + half;
      HOFS_SUB: zz = zz - half;
      default:  zz = zz;
    endcase
    r = (s.hspec == SPEC_ZERO) ? '0 : to_units(zz, 180);
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r <= tilt_out(sd_r[NSt-1].pspec, pc_r[NIt].z);
      roll_r  <= tilt_out(sd_r[NSt-1].rspec, rc_r[NIt].z);
      head_r  <= head_out(sd_r[NSt-1], hc_r[NIt].z);
    end
  end

  `TH_ASSERT_IMP(a_pop_needs_valid, pop, q_valid)
  `TH_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(head_r))
  `TH_ASSERT_IMP(a_pitch_range, out_valid, pitch_r <= 15'sd11520 && pitch_r >= -15'sd11520)

endmodule

[src/tilt_and_heading_angles.sv]
// ---------------------------------------------------------------------------
// Tilt and heading angles
// Pitch, roll and compass heading from raw accelerometer and magnetometer
// samples, in units of 1/128 degree.
// ---------------------------------------------------------------------------
// The block accepts one sample set per clock cycle while in_tready is high and
// returns one result per request in the same order. An item passes the front
// register for the squares, the queue, one load stage, 25 square-root stages,
// one CORDIC stage per iteration and a final rounding register. Throughput is
// one item per cycle while the output is not stalled, set by the fully
// pipelined root and CORDIC stages; a four-entry queue between the front and
// back parts absorbs output stalls.
module tilt_and_heading_angles
  import tha_pkg::*;
#(
  parameter int CORDIC_STEPS        = CordicStepsDef,
  parameter int ANGLE_FRACTION_BITS = AngleFracDef
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], mag_x[63:48], mag_y[79:64]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pitch_angle[14:0], roll_angle[29:15], heading_angle[45:30], zero fill
  output logic [47:0] out_tdata
);

  item_t fitem, qhead;
  logic  push, q_nf, q_ne, pop;
  logic signed [14:0] pitch, roll;
  logic signed [15:0] head;

  tha_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready),
    .ax (in_tdata[15:0]), .ay (in_tdata[31:16]), .az (in_tdata[47:32]),
    .mx (in_tdata[63:48]), .my (in_tdata[79:64]),
    .push, .item (fitem), .q_ready (q_nf)
  );

  tha_queue #(.Depth(DepthQ)) u_queue (
    .clk, .rst_n,
    .push, .push_item (fitem), .not_full (q_nf),
    .pop, .head (qhead), .not_empty (q_ne)
  );

  tha_back #(.CordicSteps(CORDIC_STEPS), .AngleFrac(ANGLE_FRACTION_BITS)) u_back (
    .clk, .rst_n,
    .q_valid (q_ne), .q_item (qhead), .pop,
    .out_valid (out_tvalid), .out_ready (out_tready),
    .pitch, .roll, .heading (head)
  );

  assign out_tdata = {2'b00, head, roll, pitch};

endmodule
